>>> hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// Item structs for both channels, register indexes and cell control.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned PAT_BYTES    = 8;   // bytes held in the pattern register
  localparam int unsigned CFG_W        = 64;  // widest register
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned LENGTH_REG_W = 4;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned OFS_OUT_W    = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_ALL       = 8'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 match_valid;
    logic [OFS_OUT_W-1:0] match_offset;
    logic                 scan_done;
    logic [COUNT_W-1:0]   match_count;
  } out_item_t;

  // per-transfer control broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell: one window byte of the scanner
// Holds one byte, passes it on to the next cell and compares the byte it is
// about to take against the pattern byte that lines up with its place.
// ----------------------------------------------------------------------------
module mbps_cell #(
  parameter int IDX = 0,
  parameter int LW  = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mbps_pkg::cell_ctrl_t               ctrl,
  input  logic [7:0]                         byte_in,
  input  logic [8*mbps_pkg::PAT_BYTES-1:0]   pattern_bytes,
  input  logic [mbps_pkg::PAT_BYTES-1:0]     wildcard_mask,
  input  logic [LW-1:0]                      len,
  output logic [7:0]                         byte_q,
  output logic                               hit
);

  logic        active;
  logic [31:0] jv;
  logic [2:0]  sel;
  logic [7:0]  want;
  logic        wild;

  // cell IDX holds window byte IDX, which faces pattern byte len-1-IDX
  always_comb begin
    active = 32'(len) > 32'(IDX);
    jv     = 32'(len) - 32'(IDX) - 32'd1;
    sel    = jv[2:0];
    want   = 8'd0;
    wild   = 1'b0;
    if (active && jv < 32'(mbps_pkg::PAT_BYTES)) begin
      want = pattern_bytes[{sel, 3'b000} +: 8];
      wild = wildcard_mask[sel];
    end
    hit = !active || wild || (byte_in == want);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      byte_q <= 8'd0;
    end else if (ctrl.shift) begin
      byte_q <= byte_in;
    end
  end

endmodule

>>> hw/rtl/masked_byte_pattern_scanner.sv
// Output: a result is on out_item in the cycle after the transfer of the byte
//   that causes it.
// Throughput: one byte per cycle unless the output stalls; the cell row compares
//   every window place in parallel; the single output register is the only buffer.
// Reset: rst (synchronous) clears registers to their defaults and the scan.
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner: wildcard byte signature search
// A row of cells holds the last MAX_PATTERN bytes; a match, the last byte or
// both produce one result item with offset and running match count.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN  = 8,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mbps_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mbps_pkg::out_item_t                out_item
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int OW = OFFSET_WIDTH;
  localparam logic [OW-1:0] OFFSET_MAX = '1;

  // registers
  logic [8*mbps_pkg::PAT_BYTES-1:0]    pattern_bytes;
  logic [mbps_pkg::PAT_BYTES-1:0]      wildcard_mask;
  logic [mbps_pkg::LENGTH_REG_W-1:0]   pattern_length;
  logic                                find_all;

  // scan state
  logic [OW-1:0]                byte_position;
  logic [OW-1:0]                next_allowed_start;
  logic                         stopped;
  logic [mbps_pkg::COUNT_W-1:0] found_count;

  logic [OW-1:0]                byte_position_next;
  logic [OW-1:0]                next_allowed_start_next;
  logic                         stopped_next;
  logic [mbps_pkg::COUNT_W-1:0] found_count_next;

  logic                  accept;
  logic [LW-1:0]         len;
  logic [7:0]            chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_hit;
  mbps_pkg::cell_ctrl_t  ctrl;

  logic          pos_ok;
  logic          cand;
  logic          hit;
  logic [OW:0]   pos_inc;
  logic [OW:0]   len_ext;
  logic [OW:0]   start_full;
  logic [OW-1:0] start;
  logic [OW:0]   adv;
  logic [OW:0]   nas_sum;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      wildcard_mask  <= '0;
      pattern_length <= 4'd1;
      find_all       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        mbps_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        mbps_pkg::REG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[7:0];
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        mbps_pkg::REG_FIND_ALL:       find_all       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // length in use: zero reads as one, large values clamp to MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = LW'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
      len = LW'(MAX_PATTERN);
    end else begin
      len = LW'(pattern_length);
    end
  end

  assign ctrl     = '{shift: accept, clear: accept && in_item.last_byte};
  assign chain[0] = in_item.data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    mbps_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .byte_in       (chain[k]),
      .pattern_bytes (pattern_bytes),
      .wildcard_mask (wildcard_mask),
      .len           (len),
      .byte_q        (chain[k+1]),
      .hit           (cell_hit[k])
    );
  end

  always_comb begin
    pos_ok     = byte_position < OFFSET_MAX;
    pos_inc    = {1'b0, byte_position} + (OW+1)'(1);
    len_ext    = (OW+1)'(len);
    start_full = pos_inc - len_ext;
    start      = start_full[OW-1:0];
    cand       = !stopped && pos_ok && (pos_inc >= len_ext);
    hit        = cand && (start >= next_allowed_start) && (&cell_hit);
    adv        = (len > LW'(1)) ? (len_ext - (OW+1)'(1)) : (OW+1)'(1);
    nas_sum    = {1'b0, start} + adv;

    byte_position_next      = pos_ok ? pos_inc[OW-1:0] : byte_position;
    next_allowed_start_next = next_allowed_start;
    stopped_next            = stopped;
    found_count_next        = found_count;
    if (hit) begin
      next_allowed_start_next = (nas_sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX
                                                                : nas_sum[OW-1:0];
      if (found_count != mbps_pkg::COUNT_MAX) begin
        found_count_next = found_count + 1'b1;
      end
      if (!find_all) begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      next_allowed_start <= '0;
      stopped            <= 1'b0;
      found_count        <= '0;
    end else if (accept) begin
      if (in_item.last_byte) begin
        byte_position      <= '0;
        next_allowed_start <= '0;
        stopped            <= 1'b0;
        found_count        <= '0;
      end else begin
        byte_position      <= byte_position_next;
        next_allowed_start <= next_allowed_start_next;
        stopped            <= stopped_next;
        found_count        <= found_count_next;
      end
    end
  end

  // output register; overwritten only when empty or being transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (hit || in_item.last_byte)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (hit || in_item.last_byte)) begin
      out_item.match_valid  <= hit;
      out_item.match_offset <= hit ? mbps_pkg::OFS_OUT_W'(start) : '0;
      out_item.scan_done    <= in_item.last_byte;
      out_item.match_count  <= found_count_next;
    end
  end

endmodule
